FILE: sv/extok_pkg.sv
// Shared types, constants and keyword tables for the expression tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package extok_pkg;

  localparam int DEF_POSITION_BITS    = 16;
  localparam int DEF_MAX_TOKEN_LENGTH = 255;

  // at most three tokens per item: closed token, single character, end
  localparam int MAX_RESULTS = 3;
  localparam int RES_BITS    = $clog2(MAX_RESULTS + 1);
  localparam int KW_COUNT    = 3;

  typedef enum logic [3:0] {
    KIND_NUM        = 4'd0,
    KIND_IDENT      = 4'd1,
    KIND_FUNCTION   = 4'd2,
    KIND_PLOT       = 4'd3,
    KIND_DERIVATIVE = 4'd4,
    KIND_OP         = 4'd5,
    KIND_LPAREN     = 4'd6,
    KIND_RPAREN     = 4'd7,
    KIND_LBRACE     = 4'd8,
    KIND_RBRACE     = 4'd9,
    KIND_COMMA      = 4'd10,
    KIND_ASSIGN     = 4'd11,
    KIND_END        = 4'd12,
    KIND_BAD        = 4'd13
  } tok_kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_NUM   = 2'd1,
    MODE_IDENT = 2'd2
  } scan_mode_t;

  // keyword index order matches the kind order from KIND_FUNCTION upwards
  localparam logic [1:0] KW_FUNCTION   = 2'd0;
  localparam logic [1:0] KW_PLOT       = 2'd1;
  localparam logic [1:0] KW_DERIVATIVE = 2'd2;

  typedef struct packed {
    tok_kind_t   kind;
    logic [15:0] start;
    logic [7:0]  length;
    logic [7:0]  tok_byte;
    logic        last;
  } token_t;

  typedef struct packed {
    token_t [MAX_RESULTS-1:0] tok;
    logic   [RES_BITS-1:0]    count;
  } scan_res_t;

  function automatic logic [3:0] kw_len(input logic [1:0] k);
    logic [3:0] len;
    unique case (k)
      KW_FUNCTION:   len = 4'd8;
      KW_PLOT:       len = 4'd4;
      KW_DERIVATIVE: len = 4'd10;
      default:       len = 4'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [3:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    unique case (k)
      KW_FUNCTION: begin
        unique case (idx)
          4'd0: ch = "f";
          4'd1: ch = "u";
          4'd2: ch = "n";
          4'd3: ch = "c";
          4'd4: ch = "t";
          4'd5: ch = "i";
          4'd6: ch = "o";
          4'd7: ch = "n";
          default: ch = 8'h00;
        endcase
      end
      KW_PLOT: begin
        unique case (idx)
          4'd0: ch = "p";
          4'd1: ch = "l";
          4'd2: ch = "o";
          4'd3: ch = "t";
          default: ch = 8'h00;
        endcase
      end
      KW_DERIVATIVE: begin
        unique case (idx)
          4'd0: ch = "d";
          4'd1: ch = "e";
          4'd2: ch = "r";
          4'd3: ch = "i";
          4'd4: ch = "v";
          4'd5: ch = "a";
          4'd6: ch = "t";
          4'd7: ch = "i";
          4'd8: ch = "v";
          4'd9: ch = "e";
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [KW_COUNT-1:0] hopes_first(input logic [7:0] c);
    logic [KW_COUNT-1:0] h;
    h = '0;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (kw_char(2'(k), 4'd0) == c) h[k] = 1'b1;
    end
    return h;
  endfunction

  function automatic tok_kind_t single_kind(input logic [7:0] c);
    tok_kind_t kd;
    unique case (c)
      "+", "-", "*", "/": kd = KIND_OP;
      "(":                kd = KIND_LPAREN;
      ")":                kd = KIND_RPAREN;
      "{":                kd = KIND_LBRACE;
      "}":                kd = KIND_RBRACE;
      ",":                kd = KIND_COMMA;
      "=":                kd = KIND_ASSIGN;
      default:            kd = KIND_BAD;
    endcase
    return kd;
  endfunction

endpackage

`default_nettype wire

FILE: sv/extok_if.sv
// Valid/ready channel interfaces for source characters and tokens.
`timescale 1ns / 1ps
`default_nettype none

interface extok_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       byte_valid;
  logic       end_of_input;

  modport source (output valid, output char_byte, output byte_valid,
                  output end_of_input, input ready);
  modport sink   (input valid, input char_byte, input byte_valid,
                  input end_of_input, output ready);
endinterface

interface extok_token_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [15:0] token_start;
  logic [7:0]  token_length;
  logic [7:0]  token_byte;
  logic        last_of_run;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output token_byte, output last_of_run,
                  input ready);
  modport sink   (input valid, input token_kind, input token_start,
                  input token_length, input token_byte, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

FILE: sv/extok_scan.sv
// Scanner state and per-character classification into up to three tokens.
`timescale 1ns / 1ps
`default_nettype none

module extok_scan #(
  parameter int POSITION_BITS    = extok_pkg::DEF_POSITION_BITS,
  parameter int MAX_TOKEN_LENGTH = extok_pkg::DEF_MAX_TOKEN_LENGTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 take,
  input  wire logic [7:0]           char_byte,
  input  wire logic                 byte_valid,
  input  wire logic                 end_of_input,
  output extok_pkg::scan_res_t      res
);
  import extok_pkg::*;

  localparam int LEN_BITS = $clog2(MAX_TOKEN_LENGTH + 1);

  scan_mode_t            mode, mode_next;
  logic [POSITION_BITS-1:0] pos, pos_next;
  logic [POSITION_BITS-1:0] ost, ost_next;
  logic [LEN_BITS-1:0]   olen, olen_next;
  logic [KW_COUNT-1:0]   hopes, hopes_next;

  logic is_dig, is_let, is_spc;

  assign is_dig = (char_byte >= "0") && (char_byte <= "9");
  assign is_let = ((char_byte >= "a") && (char_byte <= "z")) ||
                  ((char_byte >= "A") && (char_byte <= "Z"));
  assign is_spc = (char_byte == " ") || ((char_byte >= 8'd9) && (char_byte <= 8'd13));

  function automatic logic [15:0] pos16(input logic [POSITION_BITS-1:0] p);
    logic [POSITION_BITS+15:0] w;
    w = {16'b0, p};
    return w[15:0];
  endfunction

  function automatic logic [7:0] len8(input logic [LEN_BITS-1:0] l);
    logic [LEN_BITS+7:0] w;
    w = {8'b0, l};
    return w[7:0];
  endfunction

  function automatic token_t close_tok(input scan_mode_t m,
                                       input logic [POSITION_BITS-1:0] st,
                                       input logic [LEN_BITS-1:0] ln,
                                       input logic [KW_COUNT-1:0] hp);
    token_t t;
    t.kind     = KIND_NUM;
    t.start    = pos16(st);
    t.length   = len8(ln);
    t.tok_byte = 8'h00;
    t.last     = 1'b0;
    if (m == MODE_IDENT) begin
      if (hp[KW_FUNCTION] && ln == LEN_BITS'(kw_len(KW_FUNCTION)))
        t.kind = KIND_FUNCTION;
      else if (hp[KW_PLOT] && ln == LEN_BITS'(kw_len(KW_PLOT)))
        t.kind = KIND_PLOT;
      else if (hp[KW_DERIVATIVE] && ln == LEN_BITS'(kw_len(KW_DERIVATIVE)))
        t.kind = KIND_DERIVATIVE;
      else
        t.kind = KIND_IDENT;
    end
    return t;
  endfunction

  always_comb begin
    token_t [MAX_RESULTS-1:0] slot;
    logic   [RES_BITS-1:0]    n;
    tok_kind_t                sk;

    mode_next  = mode;
    pos_next   = pos;
    ost_next   = ost;
    olen_next  = olen;
    hopes_next = hopes;
    slot       = '0;
    n          = '0;
    sk         = single_kind(char_byte);

    if (byte_valid) begin
      if ((is_dig && mode != MODE_IDLE) || (is_let && mode == MODE_IDENT)) begin
        // extend the open token; drop keyword hopes that no longer match
        if (mode == MODE_IDENT) begin
          for (int k = 0; k < KW_COUNT; k++) begin
            if (hopes[k] && ((olen >= LEN_BITS'(kw_len(2'(k)))) ||
                             (kw_char(2'(k), olen[3:0]) != char_byte)))
              hopes_next[k] = 1'b0;
          end
        end
        if (olen < LEN_BITS'(MAX_TOKEN_LENGTH)) olen_next = olen + 1'b1;
      end else begin
        if (mode != MODE_IDLE) begin
          slot[n] = close_tok(mode, ost, olen, hopes);
          n = n + 1'b1;
        end
        mode_next  = MODE_IDLE;
        olen_next  = '0;
        hopes_next = '0;
        if (is_dig) begin
          mode_next = MODE_NUM;
          ost_next  = pos;
          olen_next = LEN_BITS'(1);
        end else if (is_let) begin
          mode_next  = MODE_IDENT;
          ost_next   = pos;
          olen_next  = LEN_BITS'(1);
          hopes_next = hopes_first(char_byte);
        end else if (!is_spc) begin
          slot[n].kind     = sk;
          slot[n].start    = pos16(pos);
          slot[n].length   = 8'd1;
          slot[n].tok_byte = ((sk == KIND_OP) || (sk == KIND_BAD)) ? char_byte : 8'h00;
          n = n + 1'b1;
        end
      end
      pos_next = pos + 1'b1;
    end

    if (end_of_input) begin
      if (mode_next != MODE_IDLE) begin
        slot[n] = close_tok(mode_next, ost_next, olen_next, hopes_next);
        n = n + 1'b1;
      end
      slot[n].kind     = KIND_END;
      slot[n].start    = pos16(pos_next);
      slot[n].length   = 8'd0;
      slot[n].tok_byte = 8'h00;
      n = n + 1'b1;
      mode_next  = MODE_IDLE;
      pos_next   = '0;
      ost_next   = '0;
      olen_next  = '0;
      hopes_next = '0;
    end

    for (int i = 0; i < MAX_RESULTS; i++) begin
      slot[i].last = (n != '0) && (RES_BITS'(i) == n - 1'b1);
    end

    res.tok   = slot;
    res.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_IDLE;
      pos   <= '0;
      ost   <= '0;
      olen  <= '0;
      hopes <= '0;
    end else if (take) begin
      mode  <= mode_next;
      pos   <= pos_next;
      ost   <= ost_next;
      olen  <= olen_next;
      hopes <= hopes_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/expression_tokenizer.sv
// Top level of the expression tokenizer: scanner plus token result queue.
`timescale 1ns / 1ps
`default_nettype none

// Streams source text in one ASCII character per item and gives tokens out
// one per item: numbers, identifiers, the keywords function, plot and
// derivative, operators, brackets, comma, '=' and unexpected characters,
// each as kind, start position, saturated length and character. Whitespace
// is dropped. An item with end_of_input set flushes any open token, then
// gives the end token and returns the scanner to position zero. The last
// token caused by an item carries last_of_run. Classification and scanner
// update are combinational and sit between the scanner state registers and
// a four-entry token queue. Each token leaves through the single output
// port in its own cycle; the input is taken while the queue holds at most
// one token, so a waiting token never blocks the next character.
module expression_tokenizer #(
  parameter int POSITION_BITS    = extok_pkg::DEF_POSITION_BITS,
  parameter int MAX_TOKEN_LENGTH = extok_pkg::DEF_MAX_TOKEN_LENGTH
) (
  input wire logic      clk,
  input wire logic      rst,
  extok_char_if.sink    chars,
  extok_token_if.source tokens
);
  import extok_pkg::*;

  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  scan_res_t           res;
  logic                take;
  logic                pop;
  token_t              queue [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [CNT_BITS-1:0] count, count_next;
  token_t              head;

  // take a character only while the queue has room for a full run of tokens
  assign chars.ready = (count <= CNT_BITS'(QUEUE_DEPTH - MAX_RESULTS));
  assign take        = chars.valid && chars.ready;
  assign pop         = tokens.valid && tokens.ready;

  extok_scan #(
    .POSITION_BITS    (POSITION_BITS),
    .MAX_TOKEN_LENGTH (MAX_TOKEN_LENGTH)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .char_byte    (chars.char_byte),
    .byte_valid   (chars.byte_valid),
    .end_of_input (chars.end_of_input),
    .res          (res)
  );

  // push every token of the accepted item in one go, in emission order
  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        if (RES_BITS'(i) < res.count) queue[wr_ptr + PTR_BITS'(i)] <= res.tok[i];
      end
    end
  end

  always_comb begin
    count_next = count;
    if (take) count_next = count_next + CNT_BITS'(res.count);
    if (pop)  count_next = count_next - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (take) wr_ptr <= wr_ptr + PTR_BITS'(res.count);
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count_next;
    end
  end

  // present the oldest queued token
  assign head                = queue[rd_ptr];
  assign tokens.valid        = (count != '0);
  assign tokens.token_kind   = head.kind;
  assign tokens.token_start  = head.start;
  assign tokens.token_length = head.length;
  assign tokens.token_byte   = head.tok_byte;
  assign tokens.last_of_run  = head.last;

endmodule

`default_nettype wire
